>>> hw/rtl/udp_packet_header_check_macros.svh
// ----------------------------------------------------------------------------
// UDP packet header check assertion macros
// Shared property wrappers, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef UDP_PACKET_HEADER_CHECK_MACROS_SVH
`define UDP_PACKET_HEADER_CHECK_MACROS_SVH

// same-cycle implication
`define UPHC_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define UPHC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/uphc_pkg.sv
// ----------------------------------------------------------------------------
// UDP packet header check package
// Shared types, constants and link offset lookup.
// ----------------------------------------------------------------------------
`default_nettype none

package uphc_pkg;

  localparam int COUNT_WIDTH_DEF = 16;

  localparam logic [7:0]  LINK_NULL = 8'd0;
  localparam logic [7:0]  LINK_ETH  = 8'd1;
  localparam logic [7:0]  LINK_SLIP = 8'd8;
  localparam logic [7:0]  LINK_PPP  = 8'd9;

  localparam logic [4:0]  OFF_NULL  = 5'd4;
  localparam logic [4:0]  OFF_ETH   = 5'd14;
  localparam logic [4:0]  OFF_LONG  = 5'd24;
  localparam logic [4:0]  OFF_NONE  = 5'd0;

  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [15:0] CSUM_GOOD      = 16'hFFFF;
  localparam logic [7:0]  PROTO_UDP      = 8'd17;
  localparam logic [3:0]  IP_VERSION4    = 4'd4;
  localparam logic [5:0]  IP_MIN_HDR     = 6'd20;
  localparam int          IP_MIN_LEN     = 28;
  localparam int          ETH_TYPE_HI    = 12;
  localparam int          ETH_TYPE_LO    = 13;
  localparam int          IP_PROTO_POS   = 9;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_LINK    = 3'd1,
    ST_ETYPE   = 3'd2,
    ST_SHORT   = 3'd3,
    ST_VERSION = 3'd4,
    ST_HLEN    = 3'd5,
    ST_CSUM    = 3'd6,
    ST_PROTO   = 3'd7
  } status_t;

  typedef struct packed {
    logic       valid;
    logic       last;
    logic [7:0] data;
  } hold_t;

  typedef struct packed {
    status_t    status;
    logic [4:0] ip_offset;
    logic [5:0] ip_header_bytes;
  } result_t;

  function automatic logic [4:0] link_offset(input logic [7:0] link_type);
    logic [4:0] off;
    unique case (link_type)
      LINK_NULL: off = OFF_NULL;
      LINK_ETH:  off = OFF_ETH;
      LINK_SLIP: off = OFF_LONG;
      LINK_PPP:  off = OFF_LONG;
      default:   off = OFF_NONE;
    endcase
    return off;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/uphc_in_stage.sv
// ----------------------------------------------------------------------------
// UDP packet header check input stage
// Registers one byte transaction and holds it until the parser takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module uphc_in_stage (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire logic [7:0]     in_packet_byte,
  input  wire logic           in_last_byte,
  input  wire logic           take,
  output uphc_pkg::hold_t     beat
);
  import uphc_pkg::*;

  logic       valid_r, valid_nxt;
  logic       last_r;
  logic [7:0] data_r;

  assign in_ready  = !valid_r || take;
  assign valid_nxt = in_ready ? in_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data_r <= in_packet_byte;
      last_r <= in_last_byte;
    end
  end

  assign beat.valid = valid_r;
  assign beat.last  = last_r;
  assign beat.data  = data_r;

endmodule

`default_nettype wire

>>> hw/rtl/uphc_parser.sv
// ----------------------------------------------------------------------------
// UDP packet header check parser
// Per-packet header state, ones-complement sum and final status decision.
// ----------------------------------------------------------------------------
`default_nettype none

module uphc_parser #(
  parameter int COUNT_WIDTH = uphc_pkg::COUNT_WIDTH_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic [7:0]     link_type,
  input  wire logic           step,
  input  wire uphc_pkg::hold_t beat,
  output uphc_pkg::result_t   result
);
  import uphc_pkg::*;

  typedef logic [COUNT_WIDTH-1:0] cnt_t;
  typedef logic [COUNT_WIDTH:0]   cntx_t;

  cnt_t        byte_count_r, byte_count_nxt;
  logic [15:0] type_word_r, type_word_nxt;
  logic [3:0]  ip_version_r, ip_version_nxt;
  logic [3:0]  header_words_r, header_words_nxt;
  logic [7:0]  ip_protocol_r, ip_protocol_nxt;
  logic [15:0] sum_accum_r, sum_accum_nxt;
  logic [7:0]  high_byte_hold_r, high_byte_hold_nxt;

  logic [4:0]  off;
  logic        is_eth;
  logic        in_ip;
  cnt_t        rel;
  logic        rel_first;
  logic        in_hdr;
  logic [15:0] type_cur;
  logic [3:0]  version_cur;
  logic [3:0]  words_cur;
  logic [7:0]  proto_cur;
  logic [7:0]  hold_cur;
  logic [15:0] sum_cur;
  logic [16:0] sum_add;
  logic [15:0] sum_fold;
  logic [5:0]  hbytes;
  cntx_t       pos_x;
  cntx_t       len_x;
  cntx_t       off_x;
  status_t     status;

  always_comb begin
    off       = link_offset(link_type);
    is_eth    = (link_type == LINK_ETH);
    in_ip     = (off != OFF_NONE) && (byte_count_r >= cnt_t'(off));
    rel       = byte_count_r - cnt_t'(off);
    rel_first = in_ip && (rel == '0);

    type_cur = type_word_r;
    if (is_eth && (byte_count_r == cnt_t'(ETH_TYPE_HI) ||
                   byte_count_r == cnt_t'(ETH_TYPE_LO))) begin
      type_cur = {type_word_r[7:0], beat.data};
    end

    version_cur = rel_first ? beat.data[7:4] : ip_version_r;
    words_cur   = rel_first ? beat.data[3:0] : header_words_r;
    proto_cur   = (in_ip && rel == cnt_t'(IP_PROTO_POS)) ? beat.data : ip_protocol_r;
    hbytes      = {words_cur, 2'b00};
    in_hdr      = in_ip && (rel < cnt_t'(hbytes));

    sum_add  = {1'b0, sum_accum_r} + {1'b0, high_byte_hold_r, beat.data};
    sum_fold = sum_add[16] ? (sum_add[15:0] + 16'd1) : sum_add[15:0];
    hold_cur = (in_hdr && !rel[0]) ? beat.data : high_byte_hold_r;
    sum_cur  = (in_hdr && rel[0]) ? sum_fold : sum_accum_r;

    pos_x = cntx_t'(byte_count_r);
    len_x = pos_x + cntx_t'(1);
    off_x = cntx_t'(off);

    priority if (off == OFF_NONE) begin
      status = ST_LINK;
    end else if (is_eth && len_x < cntx_t'(OFF_ETH)) begin
      status = ST_SHORT;
    end else if (is_eth && type_cur != ETHERTYPE_IPV4) begin
      status = ST_ETYPE;
    end else if (len_x < off_x + cntx_t'(IP_MIN_LEN)) begin
      status = ST_SHORT;
    end else if (version_cur != IP_VERSION4) begin
      status = ST_VERSION;
    end else if (hbytes < IP_MIN_HDR) begin
      status = ST_HLEN;
    end else if (len_x < off_x + cntx_t'(hbytes)) begin
      status = ST_SHORT;
    end else if (sum_cur != CSUM_GOOD) begin
      status = ST_CSUM;
    end else if (proto_cur != PROTO_UDP) begin
      status = ST_PROTO;
    end else begin
      status = ST_OK;
    end

    result.status          = status;
    result.ip_offset       = off;
    result.ip_header_bytes = (off == OFF_NONE) ? 6'd0 : hbytes;
  end

  always_comb begin
    byte_count_nxt     = byte_count_r;
    type_word_nxt      = type_word_r;
    ip_version_nxt     = ip_version_r;
    header_words_nxt   = header_words_r;
    ip_protocol_nxt    = ip_protocol_r;
    sum_accum_nxt      = sum_accum_r;
    high_byte_hold_nxt = high_byte_hold_r;
    if (step) begin
      if (beat.last) begin
        byte_count_nxt     = '0;
        type_word_nxt      = '0;
        ip_version_nxt     = '0;
        header_words_nxt   = '0;
        ip_protocol_nxt    = '0;
        sum_accum_nxt      = '0;
        high_byte_hold_nxt = '0;
      end else begin
        byte_count_nxt     = (&byte_count_r) ? byte_count_r : byte_count_r + cnt_t'(1);
        type_word_nxt      = type_cur;
        ip_version_nxt     = version_cur;
        header_words_nxt   = words_cur;
        ip_protocol_nxt    = proto_cur;
        sum_accum_nxt      = sum_cur;
        high_byte_hold_nxt = hold_cur;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_count_r     <= '0;
      type_word_r      <= '0;
      ip_version_r     <= '0;
      header_words_r   <= '0;
      ip_protocol_r    <= '0;
      sum_accum_r      <= '0;
      high_byte_hold_r <= '0;
    end else begin
      byte_count_r     <= byte_count_nxt;
      type_word_r      <= type_word_nxt;
      ip_version_r     <= ip_version_nxt;
      header_words_r   <= header_words_nxt;
      ip_protocol_r    <= ip_protocol_nxt;
      sum_accum_r      <= sum_accum_nxt;
      high_byte_hold_r <= high_byte_hold_nxt;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/udp_packet_header_check.sv
// A final byte passes the input register, then the output register, before its status is valid.
// Throughput: one byte per cycle; the parser consumes the input register
// every cycle unless a final byte meets a status held unclaimed in the
// output register.
// Reset: synchronous on rst_n low; link type returns to Ethernet and all
// per-packet state clears.
// ----------------------------------------------------------------------------
// UDP packet header check
// Checks link, Ethernet type and IPv4 header fields of a byte stream per packet, requiring the UDP protocol.
// ----------------------------------------------------------------------------
`default_nettype none

`include "udp_packet_header_check_macros.svh"

module udp_packet_header_check #(
  parameter int COUNT_WIDTH = uphc_pkg::COUNT_WIDTH_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [7:0] cfg_link_type,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_packet_byte,
  input  wire logic       in_last_byte,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [2:0]      out_status,
  output logic [4:0]      out_ip_offset,
  output logic [5:0]      out_ip_header_bytes
);
  import uphc_pkg::*;

  logic [7:0] link_type_r;
  hold_t      beat;
  result_t    result;
  logic       step;
  logic       out_valid_r, out_valid_nxt;
  result_t    out_res_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      link_type_r <= LINK_ETH;
    end else if (cfg_valid && cfg_ready) begin
      link_type_r <= cfg_link_type;
    end
  end

  uphc_in_stage u_in_stage (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_packet_byte (in_packet_byte),
    .in_last_byte   (in_last_byte),
    .take           (step),
    .beat           (beat)
  );

  uphc_parser #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .link_type (link_type_r),
    .step      (step),
    .beat      (beat),
    .result    (result)
  );

  // advance unless a final byte meets an unclaimed status
  assign step = beat.valid && (!beat.last || !out_valid_r || out_ready);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (step && beat.last) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step && beat.last) begin
      out_res_r <= result;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_status          = out_res_r.status;
  assign out_ip_offset       = out_res_r.ip_offset;
  assign out_ip_header_bytes = out_res_r.ip_header_bytes;

  `UPHC_ASSERT_SAME(a_stall_cause, !in_ready, beat.valid && beat.last && out_valid_r && !out_ready, "input stalled without a held status")
  `UPHC_ASSERT_NEXT(a_final_loads, step && beat.last, out_valid_r, "final byte did not produce a status")
  `UPHC_ASSERT_SAME(a_link_fields, out_valid_r && out_res_r.status == ST_LINK, out_res_r.ip_offset == OFF_NONE && out_res_r.ip_header_bytes == 6'd0, "unsupported link with non-zero fields")
  `UPHC_ASSERT_SAME(a_ok_fields, out_valid_r && out_res_r.status == ST_OK, out_res_r.ip_offset != OFF_NONE && out_res_r.ip_header_bytes >= IP_MIN_HDR, "ok status with impossible header")
  `UPHC_ASSERT_SAME(a_eth_etype, out_valid_r && out_res_r.status == ST_ETYPE, out_res_r.ip_offset == OFF_ETH, "bad ethertype on non-Ethernet offset")

endmodule

`default_nettype wire
